>>> design/mif_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mif_pkg
// shared state width constant for the modular inverse block
// ----------------------------------------------------------------------------
package mif_pkg;
	localparam int STATE_W = 3;
endpackage
`default_nettype wire

>>> design/modular_inverse_fermat.sv
`default_nettype none
// ----------------------------------------------------------------------------
// modular_inverse_fermat
// gcd check by euclid, then value^(p-2) mod p by square-and-multiply
// ----------------------------------------------------------------------------
// channel  dir  contents
// s_axis   in   tdata: value
// m_axis   out  tdata: inverse, no_inverse
// cfg      in   modulus
//
// each remainder step passes a dispatch state, then the shared restoring divider;
// each modular multiply runs by add-and-double.
// one word at a time; s_axis_tready is low while a word is in work.
// a result held on m_axis stalls the next start until taken.
// reset returns the state machine to idle and sets the modulus to 2.
module modular_inverse_fermat #(
	parameter int WIDTH = 32
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 s_axis_tvalid,
	output logic                                s_axis_tready,
	input  wire [((WIDTH + 7) / 8) * 8 - 1:0]   s_axis_tdata,   // value
	output logic                                m_axis_tvalid,
	input  wire                                 m_axis_tready,
	output logic [((WIDTH + 8) / 8) * 8 - 1:0]  m_axis_tdata,   // inverse, no_inverse
	input  wire                                 cfg_valid,
	output logic                                cfg_ready,
	input  wire [WIDTH-1:0]                     cfg_data        // modulus
);
	localparam int CW = $clog2(WIDTH + 1);

	localparam logic [mif_pkg::STATE_W-1:0] S_IDLE = 3'd0;
	localparam logic [mif_pkg::STATE_W-1:0] S_GCD  = 3'd1;
	localparam logic [mif_pkg::STATE_W-1:0] S_DIV  = 3'd2;
	localparam logic [mif_pkg::STATE_W-1:0] S_POW  = 3'd3;
	localparam logic [mif_pkg::STATE_W-1:0] S_MUL  = 3'd4;
	localparam logic [mif_pkg::STATE_W-1:0] S_OUT  = 3'd5;

	logic [mif_pkg::STATE_W-1:0] state_q;
	logic [WIDTH-1:0] mod_q, val_q, a_q, b_q, exp_q, acc_q, base_q;
	logic [WIDTH-1:0] rem_q, quo_q;
	logic [CW-1:0]    cnt_q;
	logic             div_gcd_q;  // divider serves the gcd, else the value reduction
	logic [WIDTH-1:0] mx_q, my_q, macc_q;
	logic             mul_sq_q;   // multiply is the squaring step
	logic [WIDTH-1:0] inv_q;
	logic             none_q;

	// shared mod adder: (x + y) mod m with x, y < m
	function automatic logic [WIDTH-1:0] add_mod(input logic [WIDTH-1:0] x,
		input logic [WIDTH-1:0] y, input logic [WIDTH-1:0] m);
		logic [WIDTH-1:0] gap;
		gap = m - y;
		return (x >= gap) ? x - gap : x + y;
	endfunction

	logic [WIDTH:0]   rsh;
	logic             rge;
	always_comb begin
		rsh = {rem_q, quo_q[WIDTH-1]};
		rge = rsh >= {1'b0, b_q};
	end

	assign s_axis_tready = (state_q == S_IDLE);
	assign cfg_ready     = (state_q == S_IDLE);
	assign m_axis_tvalid = (state_q == S_OUT);
	always_comb begin
		m_axis_tdata = '0;
		m_axis_tdata[WIDTH-1:0] = inv_q;
		m_axis_tdata[WIDTH]     = none_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			mod_q   <= WIDTH'(2);
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (cfg_valid) mod_q <= cfg_data;
					if (s_axis_tvalid) begin
						val_q     <= s_axis_tdata[WIDTH-1:0];
						a_q       <= s_axis_tdata[WIDTH-1:0];
						b_q       <= cfg_valid ? cfg_data : mod_q;
						div_gcd_q <= 1'b1;
						state_q   <= S_GCD;
					end
				end
				S_GCD: begin
					if (b_q == '0) begin
						if (a_q != WIDTH'(1)) begin
							none_q <= 1'b1; inv_q <= '0; state_q <= S_OUT;
						end else if (mod_q < WIDTH'(2)) begin
							none_q <= 1'b0; inv_q <= '0; state_q <= S_OUT;
						end else begin
							// reduce value mod p on the same divider
							none_q    <= 1'b0;
							div_gcd_q <= 1'b0;
							b_q       <= mod_q;
							quo_q     <= val_q;
							rem_q     <= '0;
							cnt_q     <= '0;
							state_q   <= S_DIV;
						end
					end else begin
						quo_q   <= a_q;
						rem_q   <= '0;
						cnt_q   <= '0;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (cnt_q == CW'(WIDTH)) begin
						if (div_gcd_q) begin
							a_q     <= b_q;
							b_q     <= rem_q;
							state_q <= S_GCD;
						end else begin
							base_q  <= rem_q;
							acc_q   <= WIDTH'(1);
							exp_q   <= mod_q - WIDTH'(2);
							state_q <= S_POW;
						end
					end else begin
						rem_q <= rge ? WIDTH'(rsh - {1'b0, b_q}) : rsh[WIDTH-1:0];
						quo_q <= {quo_q[WIDTH-2:0], rge};
						cnt_q <= cnt_q + CW'(1);
					end
				end
				S_POW: begin
					if (exp_q == '0) begin
						inv_q   <= acc_q;
						state_q <= S_OUT;
					end else begin
						mul_sq_q <= !exp_q[0];
						mx_q     <= exp_q[0] ? acc_q : base_q;
						my_q     <= base_q;
						macc_q   <= '0;
						state_q  <= S_MUL;
					end
				end
				S_MUL: begin
					if (my_q == '0) begin
						if (mul_sq_q) begin
							base_q  <= macc_q;
							exp_q   <= exp_q >> 1;
							state_q <= S_POW;
						end else begin
							// multiply done, now square the base
							acc_q    <= macc_q;
							mul_sq_q <= 1'b1;
							mx_q     <= base_q;
							my_q     <= base_q;
							macc_q   <= '0;
						end
					end else begin
						if (my_q[0]) macc_q <= add_mod(macc_q, mx_q, mod_q);
						mx_q <= add_mod(mx_q, mx_q, mod_q);
						my_q <= my_q >> 1;
					end
				end
				S_OUT: begin
					if (m_axis_tready) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire
